### rtl/usb_bot_pkg.sv
// ----------------------------------------------------------------------------
// USB bulk-only transport package
// Item and result words, opcodes, reply and request codes, wrapper constants.
// ----------------------------------------------------------------------------
package usb_bot_pkg;

    localparam logic [2:0] OP_HOST_OUT  = 3'd0;
    localparam logic [2:0] OP_HOST_IN   = 3'd1;
    localparam logic [2:0] OP_CHUNK_RDY = 3'd2;
    localparam logic [2:0] OP_SCSI_DONE = 3'd3;
    localparam logic [2:0] OP_RESET     = 3'd4;
    localparam logic [2:0] OP_CANCEL    = 3'd5;

    localparam logic [2:0] RK_NONE     = 3'd0;
    localparam logic [2:0] RK_ACCEPT   = 3'd1;
    localparam logic [2:0] RK_STALL    = 3'd2;
    localparam logic [2:0] RK_DEFER    = 3'd3;
    localparam logic [2:0] RK_FINISHED = 3'd4;

    localparam logic [2:0] SR_NONE       = 3'd0;
    localparam logic [2:0] SR_CMD_READ   = 3'd1;
    localparam logic [2:0] SR_CMD_WRITE  = 3'd2;
    localparam logic [2:0] SR_CMD_ONLY   = 3'd3;
    localparam logic [2:0] SR_READ_NEXT  = 3'd4;
    localparam logic [2:0] SR_WRITE_NEXT = 3'd5;

    localparam logic [1:0] PH_CMD  = 2'd0;
    localparam logic [1:0] PH_DOUT = 2'd1;
    localparam logic [1:0] PH_DIN  = 2'd2;
    localparam logic [1:0] PH_STAT = 2'd3;

    localparam logic [3:0]  EP_BULK_OUT = 4'd2;
    localparam logic [3:0]  EP_BULK_IN  = 4'd1;
    localparam logic [31:0] CBW_SIG     = 32'h4342_5355;
    localparam logic [15:0] CBW_LEN     = 16'd31;
    localparam logic [15:0] CSW_LEN     = 16'd13;
    localparam int          DIR_IN_BIT  = 7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  endpoint;
        logic [15:0] packet_len;
        logic [31:0] cbw_signature;
        logic [31:0] cbw_tag;
        logic [31:0] cbw_data_len;
        logic [7:0]  cbw_flags;
        logic [3:0]  cbw_lun;
        logic [31:0] scsi_arg;
    } bot_item_t;

    typedef struct packed {
        logic [2:0]  reply_kind;
        logic [15:0] reply_len;
        logic [2:0]  scsi_request;
        logic [3:0]  lun_out;
        logic [15:0] copy_len;
        logic        copy_to_host;
        logic [15:0] host_offset;
        logic [15:0] zero_fill_len;
        logic        csw_valid;
        logic [31:0] csw_tag;
        logic [31:0] csw_residue;
        logic        csw_status;
    } bot_result_t;

    typedef struct packed {
        logic [15:0] host_left;
        logic [15:0] host_pos;
        logic [31:0] chunk_left;
        logic [31:0] expected_left;
        logic [15:0] n;
        logic [2:0]  req;
    } bot_move_t;

endpackage

### rtl/usb_bulk_only_transport_engine.sv
// ----------------------------------------------------------------------------
// USB bulk-only transport engine
// Phase tracking, wrapper checks, copy lengths and status wrapper fields.
// ----------------------------------------------------------------------------
// One word is taken per clock while the consumer takes results, and each word
// gives one result word. A word is held in an input register, decoded against
// the phase, tag, length and packet-waiting state in a single step of logic,
// and its result is loaded into an output register once that register is free,
// from which it is offered to the consumer. The state is written in that
// same step, so the next word sees it at once. The output register holds a
// result while the consumer stalls and the input register takes one more word
// behind it.
module usb_bulk_only_transport_engine
    import usb_bot_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  bot_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output bot_result_t result
);

    logic        in_valid_reg;
    bot_item_t   in_reg;
    logic        out_valid_reg;
    bot_result_t out_reg;
    logic        fire;

    logic [1:0]  phase_reg,         phase_next;
    logic [31:0] cmd_tag_reg,       cmd_tag_next;
    logic [31:0] expected_left_reg, expected_left_next;
    logic [31:0] residue_count_reg, residue_count_next;
    logic        cmd_failed_reg,    cmd_failed_next;
    logic [31:0] chunk_left_reg,    chunk_left_next;
    logic [15:0] host_left_reg,     host_left_next;
    logic [15:0] host_pos_reg,      host_pos_next;
    logic        packet_waiting_reg, packet_waiting_next;
    bot_result_t res_next;

    function automatic bot_move_t bot_move(input logic [1:0] ph, input logic [15:0] hl,
                                           input logic [15:0] hp, input logic [31:0] chk,
                                           input logic [31:0] expl);
        bot_move_t m;
        m.n = (chk < {16'd0, hl}) ? chk[15:0] : hl;
        m.host_left = hl - m.n;
        m.host_pos = hp + m.n;
        m.chunk_left = chk - {16'd0, m.n};
        m.expected_left = expl - {16'd0, m.n};
        m.req = SR_NONE;
        if (m.chunk_left == 32'd0)
        begin
            if (ph == PH_DIN)
                m.req = SR_READ_NEXT;
            else if (ph == PH_DOUT)
                m.req = SR_WRITE_NEXT;
        end
        return m;
    endfunction

    assign fire = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || fire;
    assign result_valid = out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        logic [1:0]  ph;
        logic [31:0] expl;
        logic [31:0] res;
        logic        fail;
        logic [31:0] chk;
        logic [15:0] hl;
        logic [15:0] hp;
        logic        pw;
        logic        dp;
        logic [15:0] dp_len;
        logic        put_csw;
        bot_move_t   m;
        bot_result_t r;

        ph = phase_reg;
        expl = expected_left_reg;
        res = residue_count_reg;
        fail = cmd_failed_reg;
        chk = chunk_left_reg;
        hl = host_left_reg;
        hp = host_pos_reg;
        pw = packet_waiting_reg;
        dp = 1'b0;
        dp_len = in_reg.packet_len;
        put_csw = 1'b0;
        cmd_tag_next = cmd_tag_reg;
        r = '0;
        m = '0;

        case (in_reg.opcode)
            OP_HOST_OUT:
            begin
                if (in_reg.endpoint != EP_BULK_OUT)
                    r.reply_kind = RK_STALL;
                else if (ph == PH_CMD)
                begin
                    if (in_reg.packet_len != CBW_LEN || in_reg.cbw_signature != CBW_SIG)
                        r.reply_kind = RK_STALL;
                    else
                    begin
                        cmd_tag_next = in_reg.cbw_tag;
                        expl = in_reg.cbw_data_len;
                        if (in_reg.cbw_data_len == 32'd0)
                        begin
                            ph = PH_STAT;
                            r.scsi_request = SR_CMD_ONLY;
                        end
                        else if (in_reg.cbw_flags[DIR_IN_BIT])
                        begin
                            ph = PH_DIN;
                            r.scsi_request = SR_CMD_READ;
                        end
                        else
                        begin
                            ph = PH_DOUT;
                            r.scsi_request = SR_CMD_WRITE;
                        end
                        r.lun_out = in_reg.cbw_lun;
                        res = 32'd0;
                        r.reply_len = in_reg.packet_len;
                        r.reply_kind = RK_ACCEPT;
                    end
                end
                else if (ph == PH_DOUT)
                begin
                    if ({16'd0, in_reg.packet_len} > expl)
                        r.reply_kind = RK_STALL;
                    else
                        dp = 1'b1;
                end
                else
                    r.reply_kind = RK_STALL;
            end
            OP_HOST_IN:
            begin
                if (in_reg.endpoint != EP_BULK_IN)
                    r.reply_kind = RK_STALL;
                else if (ph == PH_DOUT)
                begin
                    if (expl != 32'd0 && in_reg.packet_len == CSW_LEN)
                    begin
                        put_csw = 1'b1;
                        r.reply_len = CSW_LEN;
                        r.reply_kind = RK_ACCEPT;
                    end
                    else if (expl != 32'd0 || in_reg.packet_len < CSW_LEN)
                        r.reply_kind = RK_STALL;
                    else
                    begin
                        hp = '0;
                        hl = '0;
                        pw = 1'b1;
                        r.reply_kind = RK_DEFER;
                    end
                end
                else if (ph == PH_STAT)
                begin
                    r.reply_kind = RK_ACCEPT;
                    if (in_reg.packet_len >= CSW_LEN)
                    begin
                        put_csw = 1'b1;
                        ph = PH_CMD;
                        r.reply_len = CSW_LEN;
                    end
                end
                else if (ph == PH_DIN)
                begin
                    if ({16'd0, in_reg.packet_len} > expl)
                        dp_len = expl[15:0];
                    dp = 1'b1;
                end
                else
                    r.reply_kind = RK_STALL;
            end
            OP_CHUNK_RDY:
            begin
                chk = in_reg.scsi_arg;
                if (pw)
                begin
                    r.host_offset = hp;
                    m = bot_move(ph, hl, hp, chk, expl);
                    r.copy_len = m.n;
                    r.copy_to_host = (ph == PH_DIN);
                    r.scsi_request = m.req;
                    hl = m.host_left;
                    hp = m.host_pos;
                    chk = m.chunk_left;
                    expl = m.expected_left;
                    if (hl == 16'd0)
                    begin
                        pw = 1'b0;
                        r.reply_len = hp;
                        r.reply_kind = RK_FINISHED;
                    end
                end
            end
            OP_SCSI_DONE:
            begin
                res = expl;
                fail = (in_reg.scsi_arg != 32'd0);
                if (pw)
                begin
                    if (expl == 32'd0 && ph == PH_DOUT)
                    begin
                        put_csw = 1'b1;
                        ph = PH_CMD;
                        r.reply_len = CSW_LEN;
                    end
                    else
                    begin
                        r.host_offset = hp;
                        r.reply_len = hp + hl;
                        if (expl != 32'd0)
                        begin
                            expl = expl - {16'd0, hl};
                            if (ph == PH_DIN)
                                r.zero_fill_len = hl;
                            hl = '0;
                        end
                        if (expl == 32'd0)
                            ph = PH_STAT;
                    end
                    pw = 1'b0;
                    r.reply_kind = RK_FINISHED;
                end
                else if (expl == 32'd0)
                    ph = PH_STAT;
            end
            OP_RESET:
                ph = PH_CMD;
            OP_CANCEL:
            begin
                pw = 1'b0;
                chk = '0;
            end
            default:
            begin
            end
        endcase

        if (dp)
        begin
            hp = '0;
            hl = dp_len;
            if (chk != 32'd0)
            begin
                m = bot_move(ph, hl, hp, chk, expl);
                r.copy_len = m.n;
                r.copy_to_host = (ph == PH_DIN);
                r.scsi_request = m.req;
                hl = m.host_left;
                hp = m.host_pos;
                chk = m.chunk_left;
                expl = m.expected_left;
            end
            if (res != 32'd0 && hl != 16'd0)
            begin
                expl = expl - {16'd0, hl};
                if (ph == PH_DIN)
                    r.zero_fill_len = hl;
                if (expl == 32'd0)
                    ph = PH_STAT;
                hl = '0;
            end
            if (hl != 16'd0)
            begin
                pw = 1'b1;
                r.reply_kind = RK_DEFER;
            end
            else
            begin
                r.reply_len = dp_len;
                r.reply_kind = RK_ACCEPT;
            end
        end

        if (put_csw)
        begin
            r.csw_valid = 1'b1;
            r.csw_tag = cmd_tag_reg;
            r.csw_residue = res;
            r.csw_status = fail;
        end

        phase_next = ph;
        expected_left_next = expl;
        residue_count_next = res;
        cmd_failed_next = fail;
        chunk_left_next = chk;
        host_left_next = hl;
        host_pos_next = hp;
        packet_waiting_next = pw;
        res_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg <= PH_CMD;
            cmd_tag_reg <= '0;
            expected_left_reg <= '0;
            residue_count_reg <= '0;
            cmd_failed_reg <= 1'b0;
            chunk_left_reg <= '0;
            host_left_reg <= '0;
            host_pos_reg <= '0;
            packet_waiting_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
                in_valid_reg <= item_valid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            if (fire)
            begin
                phase_reg <= phase_next;
                cmd_tag_reg <= cmd_tag_next;
                expected_left_reg <= expected_left_next;
                residue_count_reg <= residue_count_next;
                cmd_failed_reg <= cmd_failed_next;
                chunk_left_reg <= chunk_left_next;
                host_left_reg <= host_left_next;
                host_pos_reg <= host_pos_next;
                packet_waiting_reg <= packet_waiting_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            in_reg <= item;
        if (fire)
            out_reg <= res_next;
    end

endmodule

### rtl/usb_bot_checker.sv
// ----------------------------------------------------------------------------
// USB bulk-only transport checker
// Port-level checks on input and result words, bound to the engine.
// ----------------------------------------------------------------------------
module usb_bot_checker
    import usb_bot_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input bot_item_t   item,
    input logic        result_valid,
    input logic        result_ready,
    input bot_result_t result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("input held off without a stalled result");

    a_csw_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.csw_valid |->
            result.reply_len == CSW_LEN && result.zero_fill_len == 16'd0
            && (result.reply_kind == RK_ACCEPT || result.reply_kind == RK_FINISHED))
        else $error("status wrapper with wrong reply");

    a_stall_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.reply_kind == RK_STALL |->
            result.scsi_request == SR_NONE && !result.csw_valid
            && result.copy_len == 16'd0 && result.reply_len == 16'd0)
        else $error("stall carries side effects");

    a_item_unused: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("input word dropped while held off");

endmodule

bind usb_bulk_only_transport_engine usb_bot_checker u_usb_bot_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
